### rtl/clws_pkg.sv
// ----------------------------------------------------------------------------
// clws_pkg
// Types, codes and constant tables shared by the character LCD write
// sequencer modules.
// ----------------------------------------------------------------------------
package clws_pkg;

  // Request kinds.
  localparam logic [2:0] KIND_INIT      = 3'd0;
  localparam logic [2:0] KIND_CLEAR     = 3'd1;
  localparam logic [2:0] KIND_CURS_OFF  = 3'd2;
  localparam logic [2:0] KIND_UNDERLINE = 3'd3;
  localparam logic [2:0] KIND_OTHER_CMD = 3'd4;
  localparam logic [2:0] KIND_CHAR_POS  = 3'd5;
  localparam logic [2:0] KIND_CHAR      = 3'd6;

  // Command bytes.
  localparam logic [7:0] CMD_FUNC_SET8  = 8'h30;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h3C;
  localparam logic [7:0] CMD_NULL       = 8'h00;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CURS_OFF   = 8'h0C;
  localparam logic [7:0] CMD_UNDERLINE  = 8'h0E;
  localparam logic [7:0] CMD_OTHER      = 8'hC0;

  // DDRAM row bases.
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;
  localparam logic [7:0] ROW3_BASE = 8'h90;
  localparam logic [7:0] ROW4_BASE = 8'hD0;

  // Hold times in milliseconds.
  localparam logic [4:0] HOLD_PULSE = 5'd1;
  localparam logic [4:0] HOLD_POWER = 5'd20;
  localparam logic [4:0] HOLD_CMD   = 5'd2;
  localparam logic [4:0] HOLD_CLEAR = 5'd3;
  localparam logic [4:0] HOLD_SLOW  = 5'd5;
  localparam logic [4:0] HOLD_DATA  = 5'd10;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Index of the final byte of the init series (seven bytes).
  localparam logic [2:0] INIT_LAST_IDX = 3'd6;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] row;
    logic [4:0] col;
    logic [7:0] character;
  } req_t;

  typedef struct packed {
    logic [7:0] bus_data;
    logic       reg_select;
    logic       enable;
    logic [4:0] hold_ms;
    logic       last;
  } res_t;

  // One byte write: value, register select and tail hold.
  typedef struct packed {
    logic [7:0] value;
    logic       rs;
    logic [4:0] tail;
  } byte_t;

  // A classified request as it travels from front to back.
  typedef struct packed {
    logic       init;
    logic [2:0] last_idx;
    byte_t      b0;
    byte_t      b1;
  } job_t;

  typedef enum logic [2:0] {
    PH_SETUP  = 3'b001,
    PH_STROBE = 3'b010,
    PH_TAIL   = 3'b100
  } phase_t;

  function automatic byte_t init_byte(input logic [2:0] idx);
    byte_t b;
    b.rs = RS_CMD;
    unique case (idx)
      3'd0, 3'd1, 3'd2: begin
        b.value = CMD_FUNC_SET8;
        b.tail  = HOLD_CMD;
      end
      3'd3: begin
        b.value = CMD_FUNC_SET;
        b.tail  = HOLD_CMD;
      end
      3'd4: begin
        b.value = CMD_NULL;
        b.tail  = HOLD_SLOW;
      end
      3'd5: begin
        b.value = CMD_CLEAR;
        b.tail  = HOLD_SLOW;
      end
      default: begin
        b.value = CMD_ENTRY_MODE;
        b.tail  = HOLD_SLOW;
      end
    endcase
    return b;
  endfunction

endpackage

### rtl/clws_front.sv
// ----------------------------------------------------------------------------
// clws_front
// Classifies a request into a job of one or two byte writes, or the init
// series. Unused kinds produce no job.
// ----------------------------------------------------------------------------
module clws_front (
  input  clws_pkg::req_t request,
  output clws_pkg::job_t job,
  output logic           job_valid
);

  logic [7:0] base;
  logic [7:0] addr;

  always_comb begin
    priority if (request.row == 3'd1) begin
      base = clws_pkg::ROW1_BASE;
    end else if (request.row == 3'd2) begin
      base = clws_pkg::ROW2_BASE;
    end else if (request.row == 3'd3) begin
      base = clws_pkg::ROW3_BASE;
    end else begin
      base = clws_pkg::ROW4_BASE;
    end
  end

  // Address wraps modulo 256, so column zero lands one below the row base.
  assign addr = base + {3'b000, request.col} - 8'd1;

  always_comb begin
    job.init     = 1'b0;
    job.last_idx = 3'd0;
    job.b0.value = clws_pkg::CMD_NULL;
    job.b0.rs    = clws_pkg::RS_CMD;
    job.b0.tail  = clws_pkg::HOLD_CMD;
    job.b1.value = request.character;
    job.b1.rs    = clws_pkg::RS_DATA;
    job.b1.tail  = clws_pkg::HOLD_DATA;
    job_valid    = 1'b1;
    unique case (request.kind)
      clws_pkg::KIND_INIT: begin
        job.init     = 1'b1;
        job.last_idx = clws_pkg::INIT_LAST_IDX;
      end
      clws_pkg::KIND_CLEAR: begin
        job.b0.value = clws_pkg::CMD_CLEAR;
        job.b0.tail  = clws_pkg::HOLD_CLEAR;
      end
      clws_pkg::KIND_CURS_OFF: begin
        job.b0.value = clws_pkg::CMD_CURS_OFF;
      end
      clws_pkg::KIND_UNDERLINE: begin
        job.b0.value = clws_pkg::CMD_UNDERLINE;
      end
      clws_pkg::KIND_OTHER_CMD: begin
        job.b0.value = clws_pkg::CMD_OTHER;
      end
      clws_pkg::KIND_CHAR_POS: begin
        job.b0.value = addr;
        job.last_idx = 3'd1;
      end
      clws_pkg::KIND_CHAR: begin
        job.b0.value = request.character;
        job.b0.rs    = clws_pkg::RS_DATA;
        job.b0.tail  = clws_pkg::HOLD_DATA;
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

endmodule

### rtl/clws_queue.sv
// ----------------------------------------------------------------------------
// clws_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module clws_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  clws_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output clws_pkg::job_t rd_job,
  output logic           rd_valid
);

  clws_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !(rd_en && rd_valid)) begin
      count_next = count + 2'd1;
    end else if (!wr_en && rd_en && rd_valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en && rd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

### rtl/clws_back.sv
// ----------------------------------------------------------------------------
// clws_back
// Expands the job at the head of the queue into pin states in a result
// register, one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module clws_back (
  input  logic           clk,
  input  logic           rst,
  input  clws_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_done,
  output clws_pkg::res_t result,
  output logic           empty,
  input  logic           pop
);

  clws_pkg::phase_t phase;
  clws_pkg::phase_t phase_next;
  logic [2:0]       bidx;
  logic             pause_done;
  logic             out_valid;
  logic             advance;
  logic             emit_pause;
  logic             last_byte;
  clws_pkg::byte_t  cur;
  clws_pkg::res_t   res_next;

  assign empty      = !out_valid;
  assign advance    = job_valid && (!out_valid || pop);
  assign emit_pause = job.init && !pause_done;
  assign last_byte  = (bidx == job.last_idx);
  assign job_done   = advance && !emit_pause && (phase == clws_pkg::PH_TAIL) && last_byte;

  always_comb begin
    if (job.init) begin
      cur = clws_pkg::init_byte(bidx);
    end else if (bidx[0]) begin
      cur = job.b1;
    end else begin
      cur = job.b0;
    end
  end

  always_comb begin
    res_next.bus_data   = cur.value;
    res_next.reg_select = cur.rs;
    res_next.enable     = 1'b0;
    res_next.hold_ms    = clws_pkg::HOLD_PULSE;
    res_next.last       = 1'b0;
    phase_next          = phase;
    if (emit_pause) begin
      // Power-on wait: all pins low before the first function set.
      res_next.bus_data   = clws_pkg::CMD_NULL;
      res_next.reg_select = clws_pkg::RS_CMD;
      res_next.hold_ms    = clws_pkg::HOLD_POWER;
    end else begin
      unique case (phase)
        clws_pkg::PH_SETUP: begin
          phase_next = clws_pkg::PH_STROBE;
        end
        clws_pkg::PH_STROBE: begin
          res_next.enable = 1'b1;
          phase_next      = clws_pkg::PH_TAIL;
        end
        clws_pkg::PH_TAIL: begin
          res_next.hold_ms = cur.tail;
          res_next.last    = last_byte;
          phase_next       = clws_pkg::PH_SETUP;
        end
        default: begin
          phase_next = clws_pkg::PH_SETUP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= clws_pkg::PH_SETUP;
      bidx       <= 3'd0;
      pause_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (emit_pause) begin
          pause_done <= 1'b1;
        end else begin
          phase <= phase_next;
          if (phase == clws_pkg::PH_TAIL) begin
            if (last_byte) begin
              bidx       <= 3'd0;
              pause_done <= 1'b0;
            end else begin
              bidx <= bidx + 3'd1;
            end
          end
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

endmodule

### rtl/char_lcd_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_core
// Turns LCD requests into timed pin states for an 8-bit parallel character
// display.
//
//   Channel   Handshake        Payload
//   request   push / full      clws_pkg::req_t  (kind, row, col, character)
//   result    pop / empty      clws_pkg::res_t  (pins, hold_ms, last)
//
// One pin state leaves per cycle while the result register is empty or
// popped; the back end's single result register and sequencer set that rate.
// Up to two classified requests wait in the job queue, so requests are taken
// while results drain. A stalled result side holds the sequencer; kind 7 is
// taken and dropped. Reset is synchronous and empties the queue and the
// result register.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  clws_pkg::req_t request,
  output logic           empty,
  input  logic           pop,
  output clws_pkg::res_t result
);

  clws_pkg::job_t front_job;
  logic           front_valid;
  clws_pkg::job_t head_job;
  logic           head_valid;
  logic           job_done;
  logic           q_wr;

  assign q_wr = push && !full && front_valid;

  clws_front u_front (
    .request   (request),
    .job       (front_job),
    .job_valid (front_valid)
  );

  clws_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (job_done),
    .rd_job   (head_job),
    .rd_valid (head_valid)
  );

  clws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (head_valid),
    .job_done  (job_done),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the character LCD write sequencer against a cycle-free model of the
// pin-state series that each request should produce. A queue-fed driver and
// a checking monitor run under three idling mixes, after a directed warm-up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] KIND_UNUSED    = 3'd7;
  localparam int         RANDOM_TARGET  = 430;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = 40;

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic pop  = 1'b0;
  logic full;
  logic empty;
  clws_pkg::req_t request = '0;
  clws_pkg::res_t result;

  clws_pkg::req_t pending_requests[$];
  clws_pkg::res_t pin_states_due[$];

  int requests_taken   = 0;
  int pin_states_seen  = 0;
  int mismatches       = 0;
  int kind_count[8];
  int phase_one_start  = 0;
  int phase_two_start  = 0;
  int send_idle_pct    = 37;
  int recv_idle_pct    = 85;
  int quiet_cycles     = 0;

  char_lcd_write_sequencer_core u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Expected pin-state series
  // --------------------------------------------------------------------------
  task automatic add_pin_state(input logic [7:0] data, input logic rs, input logic en,
                               input logic [4:0] hold);
    clws_pkg::res_t ps;
    ps.bus_data   = data;
    ps.reg_select = rs;
    ps.enable     = en;
    ps.hold_ms    = hold;
    ps.last       = 1'b0;
    pin_states_due.push_back(ps);
  endtask

  task automatic add_byte_write(input logic [7:0] value, input logic rs,
                                input logic [4:0] tail);
    add_pin_state(value, rs, 1'b0, clws_pkg::HOLD_PULSE);
    add_pin_state(value, rs, 1'b1, clws_pkg::HOLD_PULSE);
    add_pin_state(value, rs, 1'b0, tail);
  endtask

  function automatic logic [7:0] ddram_address(input logic [2:0] row, input logic [4:0] col);
    logic [7:0] base;
    case (row)
      3'd1:    base = clws_pkg::ROW1_BASE;
      3'd2:    base = clws_pkg::ROW2_BASE;
      3'd3:    base = clws_pkg::ROW3_BASE;
      default: base = clws_pkg::ROW4_BASE;
    endcase
    return base + {3'b000, col} - 8'd1;
  endfunction

  task automatic sequence_request(input clws_pkg::req_t rq);
    int             before_cnt;
    clws_pkg::res_t tail_state;
    before_cnt = pin_states_due.size();
    case (rq.kind)
      clws_pkg::KIND_INIT: begin
        add_pin_state(clws_pkg::CMD_NULL, clws_pkg::RS_CMD, 1'b0, clws_pkg::HOLD_POWER);
        add_byte_write(clws_pkg::CMD_FUNC_SET8, clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
        add_byte_write(clws_pkg::CMD_FUNC_SET8, clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
        add_byte_write(clws_pkg::CMD_FUNC_SET8, clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
        add_byte_write(clws_pkg::CMD_FUNC_SET, clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
        add_byte_write(clws_pkg::CMD_NULL, clws_pkg::RS_CMD, clws_pkg::HOLD_SLOW);
        add_byte_write(clws_pkg::CMD_CLEAR, clws_pkg::RS_CMD, clws_pkg::HOLD_SLOW);
        add_byte_write(clws_pkg::CMD_ENTRY_MODE, clws_pkg::RS_CMD, clws_pkg::HOLD_SLOW);
      end
      clws_pkg::KIND_CLEAR:
        add_byte_write(clws_pkg::CMD_CLEAR, clws_pkg::RS_CMD, clws_pkg::HOLD_CLEAR);
      clws_pkg::KIND_CURS_OFF:
        add_byte_write(clws_pkg::CMD_CURS_OFF, clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
      clws_pkg::KIND_UNDERLINE:
        add_byte_write(clws_pkg::CMD_UNDERLINE, clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
      clws_pkg::KIND_OTHER_CMD:
        add_byte_write(clws_pkg::CMD_OTHER, clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
      clws_pkg::KIND_CHAR_POS: begin
        add_byte_write(ddram_address(rq.row, rq.col), clws_pkg::RS_CMD, clws_pkg::HOLD_CMD);
        add_byte_write(rq.character, clws_pkg::RS_DATA, clws_pkg::HOLD_DATA);
      end
      clws_pkg::KIND_CHAR:
        add_byte_write(rq.character, clws_pkg::RS_DATA, clws_pkg::HOLD_DATA);
      default: ;
    endcase
    // Only the final pin state of this request carries the last flag.
    if (pin_states_due.size() > before_cnt) begin
      tail_state = pin_states_due.pop_back();
      tail_state.last = 1'b1;
      pin_states_due.push_back(tail_state);
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    mismatches++;
  endtask

  task automatic check_pin_state(input clws_pkg::res_t got);
    clws_pkg::res_t want;
    if (pin_states_due.size() == 0) begin
      $display("%0t: unexpected pin state, expected none, got 0x%0h", $time, got);
      mismatches++;
    end else begin
      want = pin_states_due.pop_front();
      if (got.bus_data !== want.bus_data) report_field("bus_data", want.bus_data, got.bus_data);
      if (got.reg_select !== want.reg_select)
        report_field("reg_select", want.reg_select, got.reg_select);
      if (got.enable !== want.enable) report_field("enable", want.enable, got.enable);
      if (got.hold_ms !== want.hold_ms) report_field("hold_ms", want.hold_ms, got.hold_ms);
      if (got.last !== want.last) report_field("last", want.last, got.last);
    end
    pin_states_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Driver, monitor and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        sequence_request(request);
        kind_count[request.kind]++;
        requests_taken++;
        if (requests_taken >= phase_two_start) begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end else if (requests_taken >= phase_one_start) begin
          send_idle_pct <= 85;
          recv_idle_pct <= 37;
        end
      end
      // A request held against a full queue stays on the bus.
      if (!push || !full) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          request <= pending_requests.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_pin_state(result);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) ||
        (pending_requests.size() == 0 && !push && pin_states_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d pin states still due",
               $time, WATCHDOG_LIMIT, pin_states_due.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic clws_pkg::req_t make_req(input logic [2:0] kind, input logic [2:0] row,
                                              input logic [4:0] col, input logic [7:0] ch);
    clws_pkg::req_t rq;
    rq.kind      = kind;
    rq.row       = row;
    rq.col       = col;
    rq.character = ch;
    return rq;
  endfunction

  function automatic logic [2:0] pick_row();
    if ($urandom_range(9) == 0) return 3'($urandom_range(7));
    return 3'($urandom_range(4, 1));
  endfunction

  function automatic logic [4:0] pick_col();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31));
    return 5'($urandom_range(16, 1));
  endfunction

  initial begin
    int   counted;
    int   total;
    int   roll;
    int   run_len;

    for (int k = 0; k < 8; k++) kind_count[k] = 0;

    // Directed warm-up: every kind, the row bases, column extremes and
    // wrap-around, character extremes and the ignored kind.
    pending_requests.push_back(make_req(clws_pkg::KIND_INIT, 3'd7, 5'd31, 8'hFF));
    pending_requests.push_back(make_req(clws_pkg::KIND_CLEAR, 3'd0, 5'd0, 8'h00));
    pending_requests.push_back(make_req(clws_pkg::KIND_CURS_OFF, 3'd7, 5'd31, 8'hFF));
    pending_requests.push_back(make_req(clws_pkg::KIND_UNDERLINE, 3'd2, 5'd9, 8'h5A));
    pending_requests.push_back(make_req(clws_pkg::KIND_OTHER_CMD, 3'd0, 5'd0, 8'h00));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd1, 5'd1, 8'h00));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd2, 5'd16, 8'hFF));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd3, 5'd5, 8'h41));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd4, 5'd16, 8'h7E));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd0, 5'd1, 8'h80));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd7, 5'd31, 8'h01));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd1, 5'd0, 8'h30));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd5, 5'd0, 8'hAA));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, 3'd6, 5'd17, 8'h55));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR, 3'd7, 5'd31, 8'h00));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR, 3'd0, 5'd0, 8'hFF));
    pending_requests.push_back(make_req(KIND_UNUSED, 3'd7, 5'd31, 8'hFF));
    pending_requests.push_back(make_req(clws_pkg::KIND_CHAR, 3'd1, 5'd1, 8'h20));
    pending_requests.push_back(make_req(KIND_UNUSED, 3'd0, 5'd0, 8'h00));
    pending_requests.push_back(make_req(clws_pkg::KIND_INIT, 3'd0, 5'd0, 8'h00));
    counted = 18;

    // Mostly positioned text runs; commands, init, stray characters and the
    // ignored kind mixed in.
    while (counted < RANDOM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        pending_requests.push_back(make_req(clws_pkg::KIND_INIT, pick_row(), pick_col(),
                                            8'($urandom)));
        counted++;
      end else if (roll < 15) begin
        pending_requests.push_back(make_req(3'($urandom_range(4, 1)), 3'($urandom),
                                            5'($urandom), 8'($urandom)));
        counted++;
      end else if (roll < 20) begin
        pending_requests.push_back(make_req(KIND_UNUSED, 3'($urandom), 5'($urandom),
                                            8'($urandom)));
      end else if (roll < 27) begin
        pending_requests.push_back(make_req(clws_pkg::KIND_CHAR, 3'($urandom), 5'($urandom),
                                            8'($urandom)));
        counted++;
      end else begin
        pending_requests.push_back(make_req(clws_pkg::KIND_CHAR_POS, pick_row(), pick_col(),
                                            8'($urandom)));
        counted++;
        run_len = $urandom_range(10, 1);
        for (int i = 0; i < run_len; i++) begin
          pending_requests.push_back(make_req(clws_pkg::KIND_CHAR, 3'($urandom),
                                              5'($urandom), 8'($urandom)));
          counted++;
        end
      end
    end

    total           = pending_requests.size();
    phase_one_start = total / 3;
    phase_two_start = (2 * total) / 3;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_requests.size() != 0 || push || pin_states_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pin_states_due.size() != 0) begin
      $display("%0t: %0d pin states never arrived", $time, pin_states_due.size());
      mismatches++;
    end

    $display("Sent %0d requests: %0d init, %0d command, %0d positioned and %0d plain chars,",
             requests_taken, kind_count[clws_pkg::KIND_INIT],
             kind_count[clws_pkg::KIND_CLEAR] + kind_count[clws_pkg::KIND_CURS_OFF] +
             kind_count[clws_pkg::KIND_UNDERLINE] + kind_count[clws_pkg::KIND_OTHER_CMD],
             kind_count[clws_pkg::KIND_CHAR_POS], kind_count[clws_pkg::KIND_CHAR]);
    $display("%0d ignored; %0d pin states checked with %0d mismatches.",
             kind_count[KIND_UNUSED], pin_states_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
